// ----- sv/waveform_minmax_preview_macros.svh -----
// Assertion macros shared by the waveform min/max preview RTL.
`ifndef WAVEFORM_MINMAX_PREVIEW_MACROS_SVH
`define WAVEFORM_MINMAX_PREVIEW_MACROS_SVH
`ifndef SYNTHESIS
`define WMP_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("wmp assertion failed");
`define WMP_ASSERT_NEVER(lbl, clk, rstn, cond) \
	`WMP_ASSERT(lbl, clk, rstn, !(cond))
`else
`define WMP_ASSERT(lbl, clk, rstn, prop)
`define WMP_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- sv/wmp_pkg.sv -----
// Shared constants, types and state codes of the waveform min/max preview.
`timescale 1ns / 1ps
package wmp_pkg;

	localparam int COLUMNS     = 555;
	localparam int MAX_SAMPLES = 131072;

	localparam int COL_W     = 10;
	localparam int ADDR_IN_W = 17;
	localparam int SAMPLE_W  = 8;
	localparam int LEN_W     = 18;

	localparam int ADDR_W = $clog2(MAX_SAMPLES);
	localparam int PROD_W = COL_W + LEN_W;

	// Reciprocal of the column count, exact floor for any dividend below 2**PROD_W.
	localparam int RECIP_SHIFT = PROD_W + $clog2(COLUMNS);
	localparam int RECIP_W     = PROD_W + 1;
	localparam int MULQ_W      = PROD_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(COLUMNS) - 64'd1) / 64'(COLUMNS));

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_A,
		ST_SAVE_A,
		ST_DIV_B,
		ST_SAVE_B,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic latch;
		logic write;
		logic mul;
		logic div_step;
		logic save_start;
		logic save_end;
		logic walk_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic at_end;
	} sts_t;

endpackage

// ----- sv/wmp_if.sv -----
// Handshake channel interfaces: item input, result output, length write.
`timescale 1ns / 1ps
interface wmp_item_if import wmp_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [ADDR_IN_W-1:0]       address;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic [COL_W-1:0]           column;

	modport source (output valid, mode, address, sample_value, column, input ready);
	modport sink (input valid, mode, address, sample_value, column, output ready);
endinterface

interface wmp_result_if import wmp_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [COL_W-1:0]           column_out;
	logic signed [SAMPLE_W-1:0] min_value;
	logic signed [SAMPLE_W-1:0] max_value;
	logic                       has_data;

	modport source (output valid, column_out, min_value, max_value, has_data, input ready);
	modport sink (input valid, column_out, min_value, max_value, has_data, output ready);
endinterface

interface wmp_cfg_if import wmp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- sv/waveform_minmax_preview.sv -----
// Top level of the waveform min/max preview block.
`timescale 1ns / 1ps
// Min/max overview of a signed 8-bit sample for a 555-column display.
// A word on the item channel either loads one sample byte into the store
// (mode 0) or asks for one column (mode 1). A load gives no result. A
// query finds the bounds start and end of its column (end - start + 1
// samples) with two divisions by the column count (a reciprocal multiply
// each, then a step to clamp and save each bound), then the single read
// port of the sample store walks the range one sample a cycle; no word is
// accepted until the query is done. With an empty sample (length zero) a
// query goes from the multiply straight to the done state, with has_data
// low and min/max zero. Results sit in an output register, so a load may
// be accepted while a result waits; a query whose result is ready holds
// until that register is free. The store is not cleared after reset and
// needs no init pass: read only entries that were written. Write the
// sample length only while the block is idle; lengths above the store
// depth saturate to it, and the length write channel is always ready.
module waveform_minmax_preview import wmp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	wmp_item_if.sink   item,
	wmp_result_if.source result,
	wmp_cfg_if.sink    cfg
);

	cmd_t cmd;
	sts_t sts;

	// Length writes never stall.
	assign cfg.ready = 1'b1;

	wmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_mode  (item.mode),
		.in_ready (item.ready),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	wmp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg.valid && cfg.ready),
		.cfg_data    (cfg.data),
		.address     (item.address),
		.sample_value(item.sample_value),
		.column      (item.column),
		.column_out  (result.column_out),
		.min_value   (result.min_value),
		.max_value   (result.max_value),
		.has_data    (result.has_data)
	);

endmodule

// ----- sv/wmp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/wmp_ctrl.sv -----
// Sequencer of the waveform preview: accepts words, steps the datapath.
`timescale 1ns / 1ps
`include "waveform_minmax_preview_macros.svh"
module wmp_ctrl import wmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_mode,
	output logic in_ready,
	input  logic out_ready,
	output logic out_valid,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   in_fire;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && (in_mode == MODE_QUERY)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = sts.len_zero ? ST_DONE : ST_DIV_A;
			end
			ST_DIV_A:  state_d = ST_SAVE_A;
			ST_SAVE_A: state_d = ST_DIV_B;
			ST_DIV_B:  state_d = ST_SAVE_B;
			ST_SAVE_B: state_d = ST_WALK;
			ST_WALK: begin
				if (sts.at_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.latch = in_fire && (in_mode == MODE_QUERY);
				cmd.write = in_fire && (in_mode == MODE_LOAD);
			end
			ST_MUL:    cmd.mul = 1'b1;
			ST_DIV_A:  cmd.div_step = 1'b1;
			ST_SAVE_A: cmd.save_start = 1'b1;
			ST_DIV_B:  cmd.div_step = 1'b1;
			ST_SAVE_B: cmd.save_end = 1'b1;
			ST_WALK:   cmd.walk_step = 1'b1;
			ST_DRAIN:  cmd = '0;
			ST_DONE:   cmd.out_load = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`WMP_ASSERT(a_hold_result, clk, arst_n, (state_q == ST_DONE) && out_valid_q && !out_ready |=> (state_q == ST_DONE))
	`WMP_ASSERT(a_query_starts, clk, arst_n, in_fire && (in_mode == MODE_QUERY) |=> (state_q == ST_MUL))

endmodule

// ----- sv/wmp_dp.sv -----
// Datapath of the waveform preview: length, bounds divider, sample walk.
`timescale 1ns / 1ps
`include "waveform_minmax_preview_macros.svh"
module wmp_dp import wmp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output sts_t                       sts,
	input  logic                       cfg_we,
	input  logic [LEN_W-1:0]           cfg_data,
	input  logic [ADDR_IN_W-1:0]       address,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic [COL_W-1:0]           column,
	output logic [COL_W-1:0]           column_out,
	output logic signed [SAMPLE_W-1:0] min_value,
	output logic signed [SAMPLE_W-1:0] max_value,
	output logic                       has_data
);

	logic [LEN_W-1:0]           sample_length_q;
	logic [LEN_W-1:0]           len_sat;
	logic [LEN_W-1:0]           len_q;
	logic [COL_W-1:0]           col_q;
	logic [PROD_W-1:0]          div_q;
	logic [PROD_W-1:0]          quot_q;
	logic [ADDR_W-1:0]          start_q;
	logic [ADDR_W-1:0]          end_q;
	logic [ADDR_W-1:0]          addr_q;
	logic signed [SAMPLE_W-1:0] min_q;
	logic signed [SAMPLE_W-1:0] max_q;
	logic                       rd_vld_s1;
	logic [COL_W-1:0]           out_col_q;
	logic signed [SAMPLE_W-1:0] out_min_q;
	logic signed [SAMPLE_W-1:0] out_max_q;
	logic                       out_has_q;

	logic [MULQ_W-1:0]          mulq;
	logic [PROD_W-1:0]          len_ext;
	logic [PROD_W-1:0]          len_m1;
	logic [PROD_W-1:0]          start_calc;
	logic [PROD_W-1:0]          start_ext;
	logic [PROD_W-1:0]          em1;
	logic [PROD_W-1:0]          emax;
	logic [PROD_W-1:0]          end_calc;
	logic                       we;
	logic [SAMPLE_W-1:0]        rdata;
	logic signed [SAMPLE_W-1:0] rd_val;

	// Saturate the programmed length to the store depth.
	assign len_sat = (32'(sample_length_q) > 32'(MAX_SAMPLES)) ?
		LEN_W'(MAX_SAMPLES) : sample_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_length_q <= '0;
			rd_vld_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				sample_length_q <= cfg_data;
			end
			rd_vld_s1 <= cmd.walk_step;
		end
	end

	// Divide by the column count with one reciprocal multiply and a shift.
	assign mulq = MULQ_W'(div_q) * MULQ_W'(RECIP);

	assign len_ext   = PROD_W'(len_q);
	assign len_m1    = len_ext - PROD_W'(1);
	assign start_ext = PROD_W'(start_q);

	assign start_calc = (quot_q >= len_ext) ? len_m1 : quot_q;
	assign em1        = (quot_q == '0) ? '0 : quot_q - PROD_W'(1);
	assign emax       = (em1 < start_ext) ? start_ext : em1;
	assign end_calc   = (emax >= len_ext) ? len_m1 : emax;

	assign rd_val = signed'(rdata);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			col_q <= column;
			len_q <= len_sat;
		end
		if (cmd.mul) begin
			div_q <= PROD_W'(col_q) * PROD_W'(len_q);
		end else if (cmd.save_start) begin
			div_q   <= div_q + len_ext;
			start_q <= ADDR_W'(start_calc);
		end
		if (cmd.div_step) begin
			quot_q <= PROD_W'(mulq >> RECIP_SHIFT);
		end
		if (cmd.save_end) begin
			end_q  <= ADDR_W'(end_calc);
			addr_q <= start_q;
			min_q  <= SAMPLE_HI;
			max_q  <= SAMPLE_LO;
		end else if (cmd.walk_step) begin
			addr_q <= addr_q + ADDR_W'(1);
		end
		if (rd_vld_s1) begin
			if (rd_val < min_q) begin
				min_q <= rd_val;
			end
			if (rd_val > max_q) begin
				max_q <= rd_val;
			end
		end
		if (cmd.out_load) begin
			out_col_q <= col_q;
			out_has_q <= (len_q != '0);
			out_min_q <= (len_q == '0) ? '0 : min_q;
			out_max_q <= (len_q == '0) ? '0 : max_q;
		end
	end

	assign sts.len_zero = (len_q == '0);
	assign sts.at_end   = (addr_q == end_q);

	assign we = cmd.write && (32'(address) < 32'(MAX_SAMPLES));

	wmp_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(ADDR_W'(address)),
		.wdata(sample_value),
		.re   (cmd.walk_step),
		.raddr(addr_q),
		.rdata(rdata)
	);

	assign column_out = out_col_q;
	assign min_value  = out_min_q;
	assign max_value  = out_max_q;
	assign has_data   = out_has_q;

	`WMP_ASSERT(a_range_order, clk, arst_n, cmd.save_end |=> (start_q <= end_q))
	`WMP_ASSERT(a_end_in_len, clk, arst_n, cmd.save_end |=> (32'(end_q) < 32'(len_q)))
	`WMP_ASSERT(a_walk_bounds, clk, arst_n, cmd.walk_step |-> (addr_q >= start_q) && (addr_q <= end_q))
	`WMP_ASSERT_NEVER(a_quot_low, clk, arst_n, cmd.save_start && (64'(quot_q) * 64'(COLUMNS) > 64'(div_q)))

endmodule
